@@ rtl/tse_pkg.sv @@
// Shared constants and result type for the tree sort engine.
package tse_pkg;

    localparam int POOL_NODES_DEF = 64;
    localparam int KEY_W          = 32;
    localparam int PAY_W          = 32;
    localparam int CAP_W          = 7;
    localparam int CMD_W          = 2;

    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    localparam logic [CMD_W-1:0] CMD_CLEAR    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ADD      = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TRAVERSE = 2'd2;

    typedef struct packed {
        logic [PAY_W-1:0] payload;
        logic             has_item;
        logic             status;
        logic             last;
    } t_result;

endpackage

@@ rtl/tree_sort_engine.sv @@
// Top level of the tree sort engine: command sequencer, node pool and output register.
//
// The engine keeps an unbalanced binary search tree in a single-port node memory
// whose slot 0 is a fixed root (key 0, no payload) held in registers, so reset
// leaves the pool cleared with no sweep of the memory. One word on the slave side
// carries a command in tuser: clear returns one word marked last; add walks the
// tree from the root, keys below a node go left and all others right, so equal
// keys keep insertion order, and the new node takes the next free slot; the add
// is dropped with status 1 when the node count has reached capacity (clamped to
// 1..POOL_NODES). Traverse emits every nonzero payload in ascending key order
// with tlast on the final word, or one empty word marked last when there is none.
// Command 3 is consumed and produces nothing. Every node visit, in an add or a
// traversal, is one registered read of the node memory, and every pop of the
// return stack reads the stack memory and then reads the popped node again. A
// result word that cannot load while the previous one waits on tready holds the
// engine. One command is worked at a time; the output register lets the engine
// go on working while the previous word waits on tready. The capacity register
// must be written only while the engine is idle; the block does not enforce it.
module tree_sort_engine
    import tse_pkg::*;
#(
    parameter int POOL_NODES = POOL_NODES_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // Slave side.
    input  logic                     i_s_tvalid,
    output logic                     o_s_tready,
    input  logic [KEY_W+PAY_W-1:0]   i_s_tdata,  // key [31:0], payload [63:32]
    input  logic [CMD_W-1:0]         i_s_tuser,  // command [1:0]
    // Master side.
    output logic                     o_m_tvalid,
    input  logic                     i_m_tready,
    output logic [PAY_W-1:0]         o_m_tdata,  // payload_out [31:0]
    output logic [1:0]               o_m_tuser,  // has_item [0], status [1]
    output logic                     o_m_tlast,
    // Capacity register.
    input  logic                     i_cfg_we,
    input  logic [CAP_W-1:0]         i_cfg_wdata
);

    localparam int IW     = $clog2(POOL_NODES);
    localparam int CW     = $clog2(POOL_NODES + 1);
    localparam int NODE_W = KEY_W + PAY_W + 2 * IW;

    // Sequencer states.
    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_DONE     = 4'd1;
    localparam logic [3:0] ST_ADD_RD   = 4'd2;
    localparam logic [3:0] ST_ADD_CMP  = 4'd3;
    localparam logic [3:0] ST_ADD_NEW  = 4'd4;
    localparam logic [3:0] ST_TR_RD    = 4'd5;
    localparam logic [3:0] ST_TR_VISIT = 4'd6;
    localparam logic [3:0] ST_TR_POP   = 4'd7;
    localparam logic [3:0] ST_TR_FIN   = 4'd8;

    // Control registers.
    logic [3:0]       r_state, n_state;
    logic [CAP_W-1:0] r_cap;
    logic [CW-1:0]    r_count, n_count;
    logic [IW-1:0]    r_root_l, n_root_l;
    logic [IW-1:0]    r_root_r, n_root_r;
    logic [IW-1:0]    r_cur, n_cur;
    logic [CW-1:0]    r_sp, n_sp;
    logic             r_desc, n_desc;
    logic             r_pend_v, n_pend_v;
    logic             r_status, n_status;
    logic             r_out_v;

    // Payload registers.
    logic [KEY_W-1:0] r_key;
    logic [PAY_W-1:0] r_pay;
    logic [PAY_W-1:0] r_pend, n_pend;
    t_result          r_out;

    // Memory ports.
    logic              mem_we, mem_re;
    logic [IW-1:0]     mem_addr;
    logic [NODE_W-1:0] mem_wdata, mem_rdata;
    logic              st_we, st_re;
    logic [IW-1:0]     st_addr;
    logic [IW-1:0]     st_rdata;

    // Output loading.
    logic    out_free;
    logic    out_load;
    t_result out_next;

    // Current node as seen by the walk; the root lives in registers.
    logic [KEY_W-1:0] node_key;
    logic [PAY_W-1:0] node_pay;
    logic [IW-1:0]    node_l, node_r;
    logic             cur_is_root;
    logic             left_ok, right_ok;
    logic             go_left;
    logic [IW-1:0]    add_link;
    logic             add_link_ok;
    logic [CAP_W-1:0] eff_lim;
    logic             pool_full;
    logic             s_accept;
    logic [CW-1:0]    sp_dec;

    tse_ram #(
        .DEPTH  (POOL_NODES),
        .DATA_W (NODE_W)
    ) u_node_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_re    (mem_re),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    tse_ram #(
        .DEPTH  (POOL_NODES),
        .DATA_W (IW)
    ) u_stack_mem (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_re    (st_re),
        .i_addr  (st_addr),
        .i_wdata (r_cur),
        .o_rdata (st_rdata)
    );

    assign cur_is_root = (r_cur == '0);
    assign node_key    = cur_is_root ? '0 : mem_rdata[NODE_W-1 -: KEY_W];
    assign node_pay    = cur_is_root ? '0 : mem_rdata[2*IW +: PAY_W];
    assign node_l      = cur_is_root ? r_root_l : mem_rdata[IW +: IW];
    assign node_r      = cur_is_root ? r_root_r : mem_rdata[IW-1:0];

    // A link counts only when it points at an occupied slot.
    assign left_ok  = (node_l != '0) && (CW'(node_l) < r_count);
    assign right_ok = (node_r != '0) && (CW'(node_r) < r_count);

    assign go_left     = $signed(r_key) < $signed(node_key);
    assign add_link    = go_left ? node_l : node_r;
    assign add_link_ok = go_left ? left_ok : right_ok;

    // Capacity clamped to the range 1 to POOL_NODES.
    always_comb begin
        if (r_cap == '0) begin
            eff_lim = CAP_W'(1);
        end else if (r_cap > CAP_W'(POOL_NODES)) begin
            eff_lim = CAP_W'(POOL_NODES);
        end else begin
            eff_lim = r_cap;
        end
    end

    assign pool_full = CAP_W'(r_count) >= eff_lim;
    assign s_accept  = i_s_tvalid && o_s_tready;
    assign out_free  = !r_out_v || i_m_tready;
    assign sp_dec    = r_sp - CW'(1);

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_root_l = r_root_l;
        n_root_r = r_root_r;
        n_cur    = r_cur;
        n_sp     = r_sp;
        n_desc   = r_desc;
        n_pend_v = r_pend_v;
        n_pend   = r_pend;
        n_status = r_status;

        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_addr  = r_cur;
        mem_wdata = mem_rdata;
        st_we     = 1'b0;
        st_re     = 1'b0;
        st_addr   = r_sp[IW-1:0];

        out_load = 1'b0;
        out_next = '{payload: '0, has_item: 1'b0, status: 1'b0, last: 1'b1};

        case (r_state)
            ST_IDLE: begin
                if (s_accept) begin
                    case (i_s_tuser)
                        CMD_CLEAR: begin
                            n_root_l = '0;
                            n_root_r = '0;
                            n_count  = CW'(1);
                            n_status = 1'b0;
                            n_state  = ST_DONE;
                        end
                        CMD_ADD: begin
                            n_cur = '0;
                            if (pool_full) begin
                                n_status = 1'b1;
                                n_state  = ST_DONE;
                            end else begin
                                n_state = ST_ADD_RD;
                            end
                        end
                        CMD_TRAVERSE: begin
                            n_cur    = '0;
                            n_sp     = '0;
                            n_desc   = 1'b1;
                            n_pend_v = 1'b0;
                            n_state  = ST_TR_RD;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_DONE: begin
                if (out_free) begin
                    out_load = 1'b1;
                    out_next = '{payload: '0, has_item: 1'b0, status: r_status, last: 1'b1};
                    n_state  = ST_IDLE;
                end
            end

            ST_ADD_RD: begin
                mem_re  = 1'b1;
                n_state = ST_ADD_CMP;
            end

            ST_ADD_CMP: begin
                if (add_link_ok) begin
                    n_cur   = add_link;
                    n_state = ST_ADD_RD;
                end else begin
                    // Hang the new slot off this node, then write the slot itself.
                    if (cur_is_root) begin
                        if (go_left) begin
                            n_root_l = r_count[IW-1:0];
                        end else begin
                            n_root_r = r_count[IW-1:0];
                        end
                    end else begin
                        mem_we = 1'b1;
                        if (go_left) begin
                            mem_wdata[IW +: IW] = r_count[IW-1:0];
                        end else begin
                            mem_wdata[IW-1:0] = r_count[IW-1:0];
                        end
                    end
                    n_state = ST_ADD_NEW;
                end
            end

            ST_ADD_NEW: begin
                mem_we    = 1'b1;
                mem_addr  = r_count[IW-1:0];
                mem_wdata = {r_key, r_pay, {(2*IW){1'b0}}};
                n_count   = r_count + CW'(1);
                n_status  = 1'b0;
                n_state   = ST_DONE;
            end

            ST_TR_RD: begin
                mem_re  = 1'b1;
                n_state = ST_TR_VISIT;
            end

            ST_TR_VISIT: begin
                if (r_desc && left_ok && (r_sp < CW'(POOL_NODES))) begin
                    st_we   = 1'b1;
                    n_sp    = r_sp + CW'(1);
                    n_cur   = node_l;
                    n_state = ST_TR_RD;
                end else if ((node_pay != '0) && r_pend_v && !out_free) begin
                    n_state = ST_TR_VISIT;
                end else begin
                    // The held word is released once a later one is known to follow.
                    if (node_pay != '0) begin
                        if (r_pend_v) begin
                            out_load = 1'b1;
                            out_next = '{payload: r_pend, has_item: 1'b1, status: 1'b0,
                                         last: 1'b0};
                        end
                        n_pend_v = 1'b1;
                        n_pend   = node_pay;
                    end
                    if (right_ok) begin
                        n_cur   = node_r;
                        n_desc  = 1'b1;
                        n_state = ST_TR_RD;
                    end else if (r_sp == '0) begin
                        n_state = ST_TR_FIN;
                    end else begin
                        st_re   = 1'b1;
                        st_addr = sp_dec[IW-1:0];
                        n_sp    = sp_dec;
                        n_state = ST_TR_POP;
                    end
                end
            end

            ST_TR_POP: begin
                n_cur   = st_rdata;
                n_desc  = 1'b0;
                n_state = ST_TR_RD;
            end

            ST_TR_FIN: begin
                if (out_free) begin
                    out_load = 1'b1;
                    if (r_pend_v) begin
                        out_next = '{payload: r_pend, has_item: 1'b1, status: 1'b0,
                                     last: 1'b1};
                    end
                    n_pend_v = 1'b0;
                    n_state  = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cap    <= CAP_RESET;
            r_count  <= CW'(1);
            r_root_l <= '0;
            r_root_r <= '0;
            r_cur    <= '0;
            r_sp     <= '0;
            r_desc   <= 1'b0;
            r_pend_v <= 1'b0;
            r_status <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_root_l <= n_root_l;
            r_root_r <= n_root_r;
            r_cur    <= n_cur;
            r_sp     <= n_sp;
            r_desc   <= n_desc;
            r_pend_v <= n_pend_v;
            r_status <= n_status;
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            if (out_load) begin
                r_out_v <= 1'b1;
            end else if (i_m_tready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_key <= i_s_tdata[KEY_W-1:0];
            r_pay <= i_s_tdata[KEY_W +: PAY_W];
        end
        r_pend <= n_pend;
        if (out_load) begin
            r_out <= out_next;
        end
    end

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = r_out.payload;
    assign o_m_tuser  = {r_out.status, r_out.has_item};
    assign o_m_tlast  = r_out.last;

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count >= CW'(1)) && (r_count <= CW'(POOL_NODES)))
        else $error("node count out of range");

    a_sp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= CW'(POOL_NODES))
        else $error("return stack overflow");

    a_new_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ADD_NEW) |-> (CAP_W'(r_count) < eff_lim))
        else $error("new node written beyond the pool limit");

    a_item_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && r_out.has_item) |-> ((r_out.payload != '0) && !r_out.status))
        else $error("traversal word with empty payload or error status");

    a_busy_no_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend_v && (r_state != ST_IDLE)) |-> !o_s_tready)
        else $error("input accepted during a traversal");
`endif

endmodule

@@ rtl/tse_ram.sv @@
// Single-port synchronous memory with a registered read, used for the node pool and the stack.
module tse_ram #(
    parameter int DEPTH  = 64,
    parameter int DATA_W = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [DATA_W-1:0]        i_wdata,
    output logic [DATA_W-1:0]        o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_q;

endmodule

@@ dv/tree_sort_checker.sv @@
// Checker for the tree sort engine: tree predictor, due-word queue and field compare.
`timescale 1ns / 100ps

module tree_sort_checker
    import tse_pkg::*;
#(
    parameter int POOL_NODES = POOL_NODES_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    input  logic                   i_s_tready,
    input  logic [KEY_W+PAY_W-1:0] i_s_tdata,  // key [31:0], payload [63:32]
    input  logic [CMD_W-1:0]       i_s_tuser,  // command [1:0]
    input  logic                   i_m_tvalid,
    input  logic                   i_m_tready,
    input  logic [PAY_W-1:0]       i_m_tdata,  // payload_out [31:0]
    input  logic [1:0]             i_m_tuser,  // has_item [0], status [1]
    input  logic                   i_m_tlast,
    input  logic                   i_cfg_we,
    input  logic [CAP_W-1:0]       i_cfg_wdata,
    output int                     o_fail_count,
    output int                     o_pending
);

    localparam int IDX_W = $clog2(POOL_NODES);

    logic signed [KEY_W-1:0] node_key   [POOL_NODES];
    logic [PAY_W-1:0]        node_pay   [POOL_NODES];
    logic [IDX_W-1:0]        node_left  [POOL_NODES];
    logic [IDX_W-1:0]        node_right [POOL_NODES];
    logic [CAP_W-1:0]        node_total;
    logic [CAP_W-1:0]        capacity_reg;
    t_result                 due_words [$];

    task automatic report_mismatch(input string what, input logic [PAY_W-1:0] got,
                                   input logic [PAY_W-1:0] want);
        $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
        o_fail_count++;
    endtask

    function automatic void push_word(logic [PAY_W-1:0] pay, logic has, logic status,
                                      logic last);
        t_result word;
        word.payload  = pay;
        word.has_item = has;
        word.status   = status;
        word.last     = last;
        due_words.push_back(word);
    endfunction

    function automatic void clear_tree();
        node_key[0]   = '0;
        node_pay[0]   = '0;
        node_left[0]  = '0;
        node_right[0] = '0;
        node_total    = CAP_W'(1);
    endfunction

    // Returns the status bit: 1 when the node could not be placed.
    function automatic logic insert_node(logic signed [KEY_W-1:0] key, logic [PAY_W-1:0] pay);
        int limit;
        int cur;
        int link;
        int steps;
        logic go_left;
        limit = capacity_reg;
        if (limit < 1) limit = 1;
        if (limit > POOL_NODES) limit = POOL_NODES;
        if (node_total >= limit || node_total >= POOL_NODES) return 1'b1;
        cur = 0;
        for (steps = 0; steps < POOL_NODES; steps++) begin
            go_left = key < node_key[cur[IDX_W-1:0]];
            link = go_left ? node_left[cur[IDX_W-1:0]] : node_right[cur[IDX_W-1:0]];
            if (link != 0 && link < node_total) begin
                cur = link;
            end else begin
                if (go_left) node_left[cur[IDX_W-1:0]] = node_total[IDX_W-1:0];
                else node_right[cur[IDX_W-1:0]] = node_total[IDX_W-1:0];
                node_key[node_total[IDX_W-1:0]]   = key;
                node_pay[node_total[IDX_W-1:0]]   = pay;
                node_left[node_total[IDX_W-1:0]]  = '0;
                node_right[node_total[IDX_W-1:0]] = '0;
                node_total = node_total + CAP_W'(1);
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    // In-order walk with an explicit stack of parents still to be visited.
    function automatic void walk_in_order();
        logic [IDX_W-1:0] trail [POOL_NODES];
        int cur;
        int depth;
        int emitted;
        logic descend;
        logic done;
        t_result tail;
        cur = 0;
        depth = 0;
        emitted = 0;
        descend = 1'b1;
        done = 1'b0;
        while (!done) begin
            if (descend) begin
                while (node_left[cur[IDX_W-1:0]] != 0 &&
                       node_left[cur[IDX_W-1:0]] < node_total && depth < POOL_NODES) begin
                    trail[depth[IDX_W-1:0]] = cur[IDX_W-1:0];
                    depth++;
                    cur = node_left[cur[IDX_W-1:0]];
                end
            end
            if (node_pay[cur[IDX_W-1:0]] != 0 && emitted < POOL_NODES) begin
                push_word(node_pay[cur[IDX_W-1:0]], 1'b1, 1'b0, 1'b0);
                emitted++;
            end
            if (node_right[cur[IDX_W-1:0]] != 0 &&
                node_right[cur[IDX_W-1:0]] < node_total) begin
                cur = node_right[cur[IDX_W-1:0]];
                descend = 1'b1;
            end else if (depth == 0) begin
                done = 1'b1;
            end else begin
                depth--;
                cur = trail[depth[IDX_W-1:0]];
                descend = 1'b0;
            end
        end
        if (emitted == 0) begin
            push_word('0, 1'b0, 1'b0, 1'b1);
        end else begin
            tail = due_words.pop_back();
            tail.last = 1'b1;
            due_words.push_back(tail);
        end
    endfunction

    always @(posedge i_clk) begin
        t_result seen;
        t_result want;
        if (!i_rst_n) begin
            due_words.delete();
            capacity_reg = CAP_RESET;
            o_fail_count = 0;
            clear_tree();
        end else begin
            // Results first: a word leaving now belongs to an earlier command.
            if (i_m_tvalid && i_m_tready) begin
                seen.payload  = i_m_tdata;
                seen.has_item = i_m_tuser[0];
                seen.status   = i_m_tuser[1];
                seen.last     = i_m_tlast;
                if (due_words.size() == 0) begin
                    report_mismatch("word with nothing due", seen.payload, '0);
                end else begin
                    want = due_words.pop_front();
                    if (seen.payload !== want.payload)
                        report_mismatch("payload", seen.payload, want.payload);
                    if (seen.has_item !== want.has_item)
                        report_mismatch("has_item", seen.has_item, want.has_item);
                    if (seen.status !== want.status)
                        report_mismatch("status", seen.status, want.status);
                    if (seen.last !== want.last)
                        report_mismatch("last", seen.last, want.last);
                end
            end
            if (i_cfg_we)
                capacity_reg = i_cfg_wdata;
            if (i_s_tvalid && i_s_tready) begin
                case (i_s_tuser)
                    CMD_CLEAR: begin
                        clear_tree();
                        push_word('0, 1'b0, 1'b0, 1'b1);
                    end
                    CMD_ADD: begin
                        push_word('0, 1'b0,
                                  insert_node(i_s_tdata[KEY_W-1:0], i_s_tdata[KEY_W+:PAY_W]),
                                  1'b1);
                    end
                    CMD_TRAVERSE: walk_in_order();
                    default: ;
                endcase
            end
        end
        o_pending <= due_words.size();
    end

endmodule

@@ dv/tree_sort_engine_test.sv @@
// Testbench top for the tree sort engine: clock, reset, command stimulus and verdict.
`timescale 1ns / 100ps

module tree_sort_engine_test;
    import tse_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 5;
    // Commands wanted from the random part; ignored commands do not count.
    localparam int ITEM_TARGET   = 420;
    // Percent of cycles in which either side idles.
    localparam int IDLE_PCT      = 12;
    // Long receiver hold-off, long enough for the engine to stall its input.
    localparam int HOLD_CYCLES   = 600;
    // An ignored command is consumed as it is accepted; give the engine ample time to go idle.
    localparam int SETTLE_CYCLES = 40;
    localparam int END_CYCLES    = 300;
    // Worst case is every command a full 64-node traversal with stalls on both
    // sides; the limit is set well above it.
    localparam int LIMIT_CYCLES  = 1_000_000;
    localparam int STEADY_PHASE  = 5;
    localparam int HOLD_PHASE    = 8;

    // Command code 3 has no meaning; the engine consumes it and answers nothing.
    localparam logic [CMD_W-1:0] CMD_IGNORED = 2'd3;

    localparam int KEYS_RANDOM     = 0;
    localparam int KEYS_NARROW     = 1;
    localparam int KEYS_ASCENDING  = 2;
    localparam int KEYS_DESCENDING = 3;
    localparam int KEYS_EXTREME    = 4;

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_s_tvalid  = 1'b0;
    logic                   o_s_tready;
    logic [KEY_W+PAY_W-1:0] i_s_tdata   = '0;  // key [31:0], payload [63:32]
    logic [CMD_W-1:0]       i_s_tuser   = '0;  // command [1:0]
    logic                   o_m_tvalid;
    logic                   i_m_tready  = 1'b0;
    logic [PAY_W-1:0]       o_m_tdata;         // payload_out [31:0]
    logic [1:0]             o_m_tuser;         // has_item [0], status [1]
    logic                   o_m_tlast;
    logic                   i_cfg_we    = 1'b0;
    logic [CAP_W-1:0]       i_cfg_wdata = '0;

    int fail_count;
    int pending_words;
    int cycle_count    = 0;
    int commands_sent  = 0;
    int hold_token     = 0;
    bit sender_idles   = 1'b1;
    bit drain_idles    = 1'b1;

    always #(CLK_HALF) i_clk = ~i_clk;

    tree_sort_engine u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    tree_sort_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tuser    (i_s_tuser),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_m_tuser    (o_m_tuser),
        .i_m_tlast    (o_m_tlast),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending_words)
    );

    // A hung engine or a lost word ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("status: fail");
            $finish;
        end
    end

    // Receiver. It idles at random, and each new hold token makes it refuse
    // words for a long, counted stretch while the sender keeps offering.
    initial begin
        int hold_seen;
        hold_seen = 0;
        forever begin
            @(posedge i_clk);
            if (hold_token != hold_seen) begin
                hold_seen = hold_token;
                i_m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            i_m_tready <= !(drain_idles && $urandom_range(99) < IDLE_PCT);
        end
    end

    // Offers one command word and returns at the edge where it is taken.
    // Only one assignment to tvalid happens in any time step, so a word that
    // follows straight on keeps tvalid high without a glitch.
    task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key,
                             input logic [PAY_W-1:0] pay);
        while (sender_idles && $urandom_range(99) < IDLE_PCT) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {pay, key};
        i_s_tuser  <= cmd;
        do @(posedge i_clk); while (!o_s_tready);
        if (cmd != CMD_IGNORED)
            commands_sent++;
    endtask

    // Stops offering and waits until every due word has come back, then a
    // little longer in case an ignored command is still being consumed.
    task automatic settle(input int extra);
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_words != 0);
        repeat (extra) @(posedge i_clk);
    endtask

    // The capacity register is only written once the engine has gone idle.
    task automatic write_capacity(input logic [CAP_W-1:0] value);
        settle(SETTLE_CYCLES);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Key shapes: ascending or descending runs build deep one-sided trees,
    // narrow keys give many equal keys, extremes hit the signed limits.
    function automatic logic [KEY_W-1:0] pick_key(input int style, input int pos);
        logic [KEY_W-1:0] key;
        case (style)
            KEYS_NARROW:     key = $urandom_range(15) - 8;
            KEYS_ASCENDING:  key = pos - 20;
            KEYS_DESCENDING: key = 1000 - pos;
            KEYS_EXTREME: begin
                case ($urandom_range(4))
                    0: key = 32'h8000_0000;
                    1: key = 32'h7FFF_FFFF;
                    2: key = '0;
                    3: key = '1;
                    default: key = $urandom;
                endcase
            end
            default: key = $urandom;
        endcase
        return key;
    endfunction

    // Some payloads are zero, which the traversal must skip.
    function automatic logic [PAY_W-1:0] pick_payload();
        int roll;
        roll = $urandom_range(99);
        if (roll < 10) return '0;
        if (roll < 15) return '1;
        return $urandom;
    endfunction

    function automatic logic [CAP_W-1:0] pick_capacity();
        case ($urandom_range(5))
            0: return 7'd0;
            1: return 7'd1;
            2: return 7'd64;
            3: return 7'd127;
            default: return CAP_W'($urandom_range(2, 70));
        endcase
    endfunction

    initial begin
        int phase_no;
        int adds;
        int style;
        int roll;
        int pos;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. After reset the pool holds only the root, so the
        // first traversal is the empty case.
        send_word(CMD_TRAVERSE, $urandom, $urandom);
        // A stored node with a zero payload still gives an empty traversal.
        send_word(CMD_ADD, 32'h0000_0000, 32'h0000_0000);
        send_word(CMD_TRAVERSE, $urandom, $urandom);
        send_word(CMD_ADD, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_word(CMD_ADD, 32'h8000_0000, 32'h0000_0001);
        // Equal keys must come out in the order they went in.
        send_word(CMD_ADD, 32'd5, 32'hA5A5_A5A5);
        send_word(CMD_ADD, 32'd5, 32'h5A5A_5A5A);
        send_word(CMD_ADD, 32'hFFFF_FFFF, 32'h0000_8000);
        // A key equal to the root's key goes right of it.
        send_word(CMD_ADD, 32'h0000_0000, 32'h0000_0007);
        send_word(CMD_IGNORED, $urandom, $urandom);
        send_word(CMD_TRAVERSE, $urandom, $urandom);
        send_word(CMD_CLEAR, $urandom, $urandom);
        send_word(CMD_TRAVERSE, $urandom, $urandom);

        // Capacity zero clamps to one: the root alone fills the pool.
        write_capacity(7'd0);
        send_word(CMD_ADD, $urandom, $urandom);
        send_word(CMD_TRAVERSE, $urandom, $urandom);
        write_capacity(7'd3);
        send_word(CMD_ADD, 32'd10, 32'h1111_1111);
        send_word(CMD_ADD, 32'd9, 32'h2222_2222);
        send_word(CMD_ADD, 32'd8, 32'h3333_3333);
        send_word(CMD_TRAVERSE, $urandom, $urandom);
        // A capacity below the current node count only blocks further adds.
        write_capacity(7'd2);
        send_word(CMD_ADD, $urandom, $urandom);
        send_word(CMD_CLEAR, $urandom, $urandom);
        send_word(CMD_ADD, $urandom, 32'h4444_4444);
        send_word(CMD_ADD, $urandom, 32'h5555_5555);
        send_word(CMD_TRAVERSE, $urandom, $urandom);
        // A capacity above the pool size clamps to the pool size.
        write_capacity(7'd127);

        // Random part: phases of a usual clear, a run of adds and a closing traversal,
        // with noise words and early traversals mixed in.
        commands_sent = 0;
        phase_no = 0;
        while (commands_sent < ITEM_TARGET) begin
            phase_no++;
            if ($urandom_range(99) < 40)
                write_capacity(pick_capacity());

            // One phase runs with no idling on either side.
            sender_idles = (phase_no != STEADY_PHASE);
            drain_idles <= (phase_no != STEADY_PHASE);
            if (phase_no == HOLD_PHASE)
                hold_token <= hold_token + 1;

            roll = $urandom_range(99);
            if (phase_no == HOLD_PHASE || roll < 5) adds = $urandom_range(60, 70);
            else if (phase_no == STEADY_PHASE || roll < 20) adds = $urandom_range(13, 40);
            else adds = $urandom_range(1, 12);
            style = $urandom_range(KEYS_EXTREME);

            // Now and then the tree keeps growing across phases.
            if ($urandom_range(99) < 80)
                send_word(CMD_CLEAR, $urandom, $urandom);
            for (pos = 0; pos < adds; pos++) begin
                if ($urandom_range(99) < 4)
                    send_word(CMD_IGNORED, $urandom, $urandom);
                if ($urandom_range(99) < 6)
                    send_word(CMD_TRAVERSE, $urandom, $urandom);
                send_word(CMD_ADD, pick_key(style, pos), pick_payload());
            end
            send_word(CMD_TRAVERSE, $urandom, $urandom);
        end
        sender_idles = 1'b1;
        drain_idles <= 1'b1;

        settle(END_CYCLES);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
